// ----- hw/rtl/csb_pkg.sv -----
// Shared types, register indexes and palette for the clipped sprite blitter.
package csb_pkg;

	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned PROD_W    = 21;
	localparam int unsigned COORD_W   = 12;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 11;
	localparam int unsigned Q_DEPTH   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OPAQUE = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [3:0]        idx0;
		logic [3:0]        idx1;
		logic              draw0;
		logic              draw1;
	} csb_entry_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} csb_rgb_t;

	function automatic csb_rgb_t csb_palette(input logic [3:0] idx);
		csb_rgb_t c;
		case (idx)
			4'd0:    c = '{8'h00, 8'h00, 8'h00};
			4'd1:    c = '{8'h00, 8'h00, 8'hAA};
			4'd2:    c = '{8'h00, 8'hAA, 8'h00};
			4'd3:    c = '{8'h00, 8'hAA, 8'hAA};
			4'd4:    c = '{8'hAA, 8'h00, 8'h00};
			4'd5:    c = '{8'hAA, 8'h00, 8'hAA};
			4'd6:    c = '{8'hAA, 8'h55, 8'h00};
			4'd7:    c = '{8'hAA, 8'hAA, 8'hAA};
			4'd8:    c = '{8'h55, 8'h55, 8'h55};
			4'd9:    c = '{8'h55, 8'h55, 8'hFF};
			4'd10:   c = '{8'h00, 8'hFF, 8'h55};
			4'd11:   c = '{8'h55, 8'hFF, 8'hFF};
			4'd12:   c = '{8'hFF, 8'h55, 8'h55};
			4'd13:   c = '{8'hFF, 8'h55, 8'hFF};
			4'd14:   c = '{8'hFF, 8'hFF, 8'h55};
			default: c = '{8'hFF, 8'hFF, 8'hFF};
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/clipped_sprite_blitter.sv -----
// Clipped 4bpp palette sprite blitter top level.
// Flow: an accepted pair is written into the queue; the back end pops it and registers its
// first write request when the output is free, the second (if any) once the first is taken.
// Throughput: one pair per cycle on input while the queue is not full; output gives one write
// per cycle while write_stall is low, so pairs with both pixels drawn are bound by the single write port.
// Reset: async active low clears config registers, sprite counters and queue.
module clipped_sprite_blitter import csb_pkg::*; #(
	parameter int unsigned SCREEN_WIDTH  = 320,
	parameter int unsigned SCREEN_HEIGHT = 200
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic [7:0]           pixel_pair,
	output logic                 write_valid,
	input  logic                 write_stall,
	output logic [ADDR_W-1:0]    screen_address,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic                 last_of_run
);

	logic       push, pop, q_full, q_valid;
	csb_entry_t push_entry, head;

	assign cfg_ready   = 1'b1;
	assign pixel_stall = q_full;

	csb_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.q_full      (q_full),
		.pixel_pair  (pixel_pair),
		.push        (push),
		.push_entry  (push_entry)
	);

	csb_fifo #(
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.q_full     (q_full),
		.q_valid    (q_valid),
		.head       (head)
	);

	csb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.head           (head),
		.pop            (pop),
		.write_stall    (write_stall),
		.write_valid    (write_valid),
		.screen_address (screen_address),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.last_of_run    (last_of_run)
	);

endmodule

// ----- hw/rtl/csb_front.sv -----
// Front end: config registers, sprite counters, clipping and address generation.
module csb_front import csb_pkg::*; #(
	parameter int unsigned SCREEN_WIDTH  = 320,
	parameter int unsigned SCREEN_HEIGHT = 200
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 pixel_valid,
	input  logic                 q_full,
	input  logic [7:0]           pixel_pair,
	output logic                 push,
	output csb_entry_t           push_entry
);

	localparam logic signed [COORD_W-1:0] SW_S = COORD_W'(SCREEN_WIDTH);
	localparam logic signed [COORD_W-1:0] SH_S = COORD_W'(SCREEN_HEIGHT);

	logic [10:0] left_q;
	logic [10:0] top_q;
	logic [9:0]  width_q;
	logic [9:0]  height_q;
	logic        opaque_q;
	logic [9:0]  row_q;
	logic [8:0]  col_q;

	logic                      accept;
	logic                      empty_sprite;
	logic [8:0]                bpr;
	logic signed [COORD_W-1:0] x0, x1, xb, y;
	logic                      y_vis, draw0, draw1;
	logic [PROD_W-1:0]         lin;
	logic [9:0]                col_inc;
	logic [10:0]               row_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			opaque_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LEFT:   left_q   <= cfg_data;
				CFG_TOP:    top_q    <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data[9:0];
				CFG_HEIGHT: height_q <= cfg_data[9:0];
				CFG_OPAQUE: opaque_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept       = pixel_valid && !q_full;
	assign bpr          = width_q[9:1];
	assign empty_sprite = (bpr == '0) || (height_q == '0);

	assign x0 = $signed({left_q[10], left_q}) + $signed({2'b00, col_q, 1'b0});
	assign x1 = x0 + COORD_W'(1);
	assign y  = $signed({top_q[10], top_q}) + $signed({2'b00, row_q});

	assign y_vis = (y >= 0) && (y < SH_S);
	assign draw0 = y_vis && (x0 >= 0) && (x0 < SW_S)
		&& (opaque_q || (pixel_pair[7:4] != 4'd0));
	assign draw1 = y_vis && (x1 >= 0) && (x1 < SW_S)
		&& (opaque_q || (pixel_pair[3:0] != 4'd0));

	// address of the first drawn pixel; if both are drawn, a second write follows at +1
	assign xb  = draw0 ? x0 : x1;
	assign lin = PROD_W'(y[9:0]) * PROD_W'(SCREEN_WIDTH) + PROD_W'(xb[9:0]);

	assign push             = accept && !empty_sprite && (draw0 || draw1);
	assign push_entry.addr  = lin[ADDR_W-1:0];
	assign push_entry.idx0  = pixel_pair[7:4];
	assign push_entry.idx1  = pixel_pair[3:0];
	assign push_entry.draw0 = draw0;
	assign push_entry.draw1 = draw1;

	assign col_inc = {1'b0, col_q} + 10'd1;
	assign row_inc = {1'b0, row_q} + 11'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept && !empty_sprite) begin
			if (col_inc >= {1'b0, bpr}) begin
				col_q <= '0;
				row_q <= (row_inc >= {1'b0, height_q}) ? '0 : row_inc[9:0];
			end else begin
				col_q <= col_inc[8:0];
			end
		end
	end

endmodule

// ----- hw/rtl/csb_fifo.sv -----
// Short queue of classified pixel pairs between front and back end.
module csb_fifo import csb_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  csb_entry_t push_entry,
	input  logic       pop,
	output logic       q_full,
	output logic       q_valid,
	output csb_entry_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	csb_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && push && !pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !q_valid))
		else $error("pop from empty queue");

endmodule

// ----- hw/rtl/csb_back.sv -----
// Back end: expands queued pairs into framebuffer write requests, one per cycle while write_stall is low.
module csb_back import csb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  csb_entry_t        head,
	output logic              pop,
	input  logic              write_stall,
	output logic              write_valid,
	output logic [ADDR_W-1:0] screen_address,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              last_of_run
);

	logic              valid_q;
	logic              pend_q;
	logic [3:0]        pend_idx_q;
	logic [ADDR_W-1:0] addr_q;
	logic [3:0]        idx_q;
	logic              last_q;
	logic              out_free;
	csb_rgb_t          rgb;

	assign out_free = !valid_q || !write_stall;
	assign pop      = out_free && !pend_q && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (q_valid) begin
				valid_q <= 1'b1;
				pend_q  <= head.draw0 && head.draw1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				addr_q <= addr_q + ADDR_W'(1);
				idx_q  <= pend_idx_q;
				last_q <= 1'b1;
			end else if (q_valid) begin
				addr_q     <= head.addr;
				idx_q      <= head.draw0 ? head.idx0 : head.idx1;
				last_q     <= !(head.draw0 && head.draw1);
				pend_idx_q <= head.idx1;
			end
		end
	end

	assign rgb            = csb_palette(idx_q);
	assign write_valid    = valid_q;
	assign screen_address = addr_q;
	assign red            = rgb.r;
	assign green          = rgb.g;
	assign blue           = rgb.b;
	assign last_of_run    = last_q;

	a_pend_has_first: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (valid_q && !last_q))
		else $error("second pixel pending without first write shown");

	a_second_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && out_free) |=> (valid_q && last_q && !pend_q))
		else $error("second pixel write not marked last");

endmodule
